// ----- rtl/tah_pkg.sv -----
// Shared types, widths and constants for the averaging thermostat.
// No dependencies; every other file in rtl/ imports this package.
package tah_pkg;

  localparam int SAMPLE_W          = 10;
  localparam int TEMP_W            = 10;
  localparam int SETPOINT_W        = 8;
  localparam int TOL_W             = 4;
  // remainder modulo AVERAGE_COUNT, which is at most 64
  localparam int REM_W             = 6;

  localparam int AVERAGE_COUNT_DEF = 8;
  localparam int SCALE_DIVISOR_DEF = 2;

  // avg / 33 as (avg * CORR_MULT) >> CORR_SHIFT, exact for 10-bit avg
  localparam int CORR_SHIFT        = 16;
  localparam int CORR_MULT_W       = 11;
  localparam logic [CORR_MULT_W-1:0] CORR_MULT = 11'd1986;

  localparam logic [TEMP_W-1:0]     MIN_TEMP     = 10'd2;
  localparam logic [TEMP_W-1:0]     RESET_TEMP   = 10'd25;
  localparam logic [SETPOINT_W-1:0] RESET_TARGET = 8'd27;
  localparam logic [SETPOINT_W-1:0] SETPOINT_MAX = 8'd255;
  localparam logic [TOL_W-1:0]      RESET_TOL    = 4'd1;

  typedef enum logic [1:0] {
    MODE_SAMPLE  = 2'd0,
    MODE_UP      = 2'd1,
    MODE_DOWN    = 2'd2,
    MODE_RESTART = 2'd3
  } tah_mode_t;

  typedef enum logic [1:0] {
    STATUS_NORMAL = 2'd0,
    STATUS_HOT    = 2'd1,
    STATUS_COLD   = 2'd2
  } tah_status_t;

  typedef struct packed {
    tah_mode_t           mode;
    logic [SAMPLE_W-1:0] sample;
  } tah_in_t;

  typedef struct packed {
    logic [TEMP_W-1:0]     temperature;
    tah_status_t           status;
    logic                  compressor_on;
    logic [SETPOINT_W-1:0] setpoint;
  } tah_out_t;

  typedef struct packed {
    tah_mode_t           mode;
    logic [SAMPLE_W-1:0] value;
  } tah_scaled_t;

  typedef struct packed {
    tah_mode_t           mode;
    logic [SAMPLE_W-1:0] quot;
    logic [REM_W-1:0]    rem;
  } tah_split_t;

  typedef struct packed {
    tah_mode_t         mode;
    logic [TEMP_W-1:0] temp;
  } tah_temp_t;

endpackage

// ----- rtl/thermostat_average_hysteresis.sv -----
// Top level of the averaging thermostat: input register and the stage chain.
// Uses tah_pkg, tah_prescale, tah_split, tah_average, tah_correct, tah_control.
//
// Accepts one beat per clock when the result side keeps up: each stage is a
// register with its own valid bit, so bubbles are squeezed out and input is
// taken while a finished result waits. A beat passes seven registers (input,
// prescale, quotient, remainder, accumulate, correct, result); the input
// register loads at the accepting edge. A sample beat that does not
// complete an average of AVERAGE_COUNT samples is absorbed in the accumulator
// and gives no result; setpoint and restart beats always give one. Samples
// are divided by SCALE_DIVISOR before they are summed. The tolerance register
// resets to 1 and should be written only while no beat is in flight.
module thermostat_average_hysteresis
  import tah_pkg::*;
#(
  parameter int AVERAGE_COUNT = AVERAGE_COUNT_DEF,
  parameter int SCALE_DIVISOR = SCALE_DIVISOR_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [TOL_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  tah_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output tah_out_t         out_data
);

  logic        in_valid_r;
  tah_in_t     in_data_r;
  logic        in_ready;

  logic        pre_ready;
  logic        pre_valid;
  tah_scaled_t pre_data;
  logic        spl_ready;
  logic        spl_valid;
  tah_split_t  spl_data;
  logic        avg_ready;
  logic        avg_valid;
  tah_temp_t   avg_data;
  logic        cor_ready;
  logic        cor_valid;
  tah_temp_t   cor_data;
  logic        ctl_ready;

  assign in_ready = !in_valid_r || pre_ready;
  assign in_stall = !in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
  end

  tah_prescale #(
    .SCALE_DIVISOR(SCALE_DIVISOR)
  ) u_prescale (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid_r),
    .in_ready (pre_ready),
    .in_data  (in_data_r),
    .out_valid(pre_valid),
    .out_ready(spl_ready),
    .out_data (pre_data)
  );

  tah_split #(
    .AVERAGE_COUNT(AVERAGE_COUNT)
  ) u_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (pre_valid),
    .in_ready (spl_ready),
    .in_data  (pre_data),
    .out_valid(spl_valid),
    .out_ready(avg_ready),
    .out_data (spl_data)
  );

  tah_average #(
    .AVERAGE_COUNT(AVERAGE_COUNT)
  ) u_average (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (spl_valid),
    .in_ready (avg_ready),
    .in_data  (spl_data),
    .out_valid(avg_valid),
    .out_ready(cor_ready),
    .out_data (avg_data)
  );

  tah_correct u_correct (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (avg_valid),
    .in_ready (cor_ready),
    .in_data  (avg_data),
    .out_valid(cor_valid),
    .out_ready(ctl_ready),
    .out_data (cor_data)
  );

  tah_control u_control (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (cor_valid),
    .in_ready (ctl_ready),
    .in_data  (cor_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

// ----- rtl/tah_prescale.sv -----
// Pipeline stage: divides the converter sample by SCALE_DIVISOR.
// Uses tah_pkg; reciprocal multiply, exact for every 10-bit sample.
module tah_prescale
  import tah_pkg::*;
#(
  parameter int SCALE_DIVISOR = SCALE_DIVISOR_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  tah_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output tah_scaled_t out_data
);

  localparam int DIV_SHIFT = SAMPLE_W + $clog2(SCALE_DIVISOR);
  localparam int DIV_MULT  = ((1 << DIV_SHIFT) + SCALE_DIVISOR - 1) / SCALE_DIVISOR;
  localparam int PROD_W    = SAMPLE_W + DIV_SHIFT + 1;

  logic              out_valid_r;
  tah_scaled_t       out_data_r;
  tah_scaled_t       out_data_nxt;
  logic [PROD_W-1:0] prod;

  assign in_ready = !out_valid_r || out_ready;
  assign prod     = PROD_W'(in_data.sample) * PROD_W'(DIV_MULT);

  always_comb begin
    out_data_nxt.mode  = in_data.mode;
    out_data_nxt.value = prod[DIV_SHIFT +: SAMPLE_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/tah_split.sv -----
// Two pipeline stages: split the scaled sample into quotient and
// remainder by AVERAGE_COUNT. Uses tah_pkg.
module tah_split
  import tah_pkg::*;
#(
  parameter int AVERAGE_COUNT = AVERAGE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  tah_scaled_t in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output tah_split_t  out_data
);

  localparam int DIV_SHIFT = SAMPLE_W + $clog2(AVERAGE_COUNT);
  localparam int DIV_MULT  = ((1 << DIV_SHIFT) + AVERAGE_COUNT - 1) / AVERAGE_COUNT;
  localparam int PROD_W    = SAMPLE_W + DIV_SHIFT + 1;
  localparam int BACK_W    = SAMPLE_W + REM_W + 1;

  // quotient stage
  logic                mid_valid_r;
  logic                mid_ready;
  tah_mode_t           mid_mode_r;
  logic [SAMPLE_W-1:0] mid_value_r;
  logic [SAMPLE_W-1:0] mid_quot_r;
  logic [PROD_W-1:0]   quot_prod;

  // remainder stage
  logic                out_valid_r;
  tah_split_t          out_data_r;
  tah_split_t          out_data_nxt;
  logic [BACK_W-1:0]   back_prod;
  logic [BACK_W-1:0]   diff;

  assign mid_ready = !out_valid_r || out_ready;
  assign in_ready  = !mid_valid_r || mid_ready;
  assign quot_prod = PROD_W'(in_data.value) * PROD_W'(DIV_MULT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_valid_r <= 1'b0;
    end else if (in_ready) begin
      mid_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mid_mode_r  <= in_data.mode;
      mid_value_r <= in_data.value;
      mid_quot_r  <= quot_prod[DIV_SHIFT +: SAMPLE_W];
    end
  end

  assign back_prod = BACK_W'(mid_quot_r) * BACK_W'(AVERAGE_COUNT);
  assign diff      = BACK_W'(mid_value_r) - back_prod;

  always_comb begin
    out_data_nxt.mode = mid_mode_r;
    out_data_nxt.quot = mid_quot_r;
    out_data_nxt.rem  = diff[REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (mid_ready) begin
      out_valid_r <= mid_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_ready && mid_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/tah_average.sv -----
// Accumulator stage: keeps the running sum as quotient and remainder
// by AVERAGE_COUNT and emits the ceiling average. Uses tah_pkg.
module tah_average
  import tah_pkg::*;
#(
  parameter int AVERAGE_COUNT = AVERAGE_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  tah_split_t in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output tah_temp_t  out_data
);

  localparam int CNT_W = $clog2(AVERAGE_COUNT + 1);

  logic [SAMPLE_W-1:0] quot_r;
  logic [SAMPLE_W-1:0] quot_nxt;
  logic [REM_W-1:0]    rem_r;
  logic [REM_W-1:0]    rem_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    cnt_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  tah_temp_t           out_data_r;
  tah_temp_t           out_data_nxt;

  logic                take;
  logic [REM_W:0]      rem_sum;
  logic                carry;
  logic [REM_W-1:0]    rem_new;
  logic [SAMPLE_W:0]   quot_sum;
  logic [SAMPLE_W-1:0] quot_new;
  logic [CNT_W-1:0]    cnt_inc;
  logic [SAMPLE_W:0]   avg_sum;

  assign in_ready = !out_valid_r || out_ready;
  assign take     = in_valid && in_ready;

  assign rem_sum  = {1'b0, rem_r} + {1'b0, in_data.rem};
  assign carry    = rem_sum >= (REM_W + 1)'(AVERAGE_COUNT);
  assign rem_new  = carry ? REM_W'(rem_sum - (REM_W + 1)'(AVERAGE_COUNT))
                          : rem_sum[REM_W-1:0];
  assign quot_sum = {1'b0, quot_r} + {1'b0, in_data.quot} + (SAMPLE_W + 1)'(carry);
  assign quot_new = quot_sum[SAMPLE_W-1:0];
  assign cnt_inc  = cnt_r + CNT_W'(1);
  // ceiling: round up when anything is left over
  assign avg_sum  = {1'b0, quot_new} + (SAMPLE_W + 1)'(rem_new != '0);

  always_comb begin
    quot_nxt          = quot_r;
    rem_nxt           = rem_r;
    cnt_nxt           = cnt_r;
    out_valid_nxt     = 1'b0;
    out_data_nxt.mode = in_data.mode;
    out_data_nxt.temp = avg_sum[TEMP_W-1:0];
    if (take) begin
      case (in_data.mode)
        MODE_SAMPLE: begin
          if (cnt_inc == CNT_W'(AVERAGE_COUNT)) begin
            quot_nxt      = '0;
            rem_nxt       = '0;
            cnt_nxt       = '0;
            out_valid_nxt = 1'b1;
          end else begin
            // partial average: absorb the beat, emit nothing
            quot_nxt = quot_new;
            rem_nxt  = rem_new;
            cnt_nxt  = cnt_inc;
          end
        end
        MODE_RESTART: begin
          quot_nxt      = '0;
          rem_nxt       = '0;
          cnt_nxt       = '0;
          out_valid_nxt = 1'b1;
        end
        default: begin
          out_valid_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quot_r      <= '0;
      rem_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
      cnt_r  <= cnt_nxt;
      if (in_ready) begin
        out_valid_r <= out_valid_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/tah_correct.sv -----
// Pipeline stage: subtracts one thirty-third of the average and clamps
// the result to the minimum temperature. Uses tah_pkg.
module tah_correct
  import tah_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  tah_temp_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output tah_temp_t out_data
);

  localparam int PROD_W = TEMP_W + CORR_MULT_W;

  logic              out_valid_r;
  tah_temp_t         out_data_r;
  tah_temp_t         out_data_nxt;
  logic [PROD_W-1:0] prod;
  logic [TEMP_W-1:0] share;
  logic [TEMP_W-1:0] reduced;

  assign in_ready = !out_valid_r || out_ready;
  assign prod     = PROD_W'(in_data.temp) * PROD_W'(CORR_MULT);
  assign share    = prod[CORR_SHIFT +: TEMP_W];
  assign reduced  = in_data.temp - share;

  always_comb begin
    out_data_nxt.mode = in_data.mode;
    out_data_nxt.temp = (reduced < MIN_TEMP) ? MIN_TEMP : reduced;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/tah_control.sv -----
// Control stage and result register: setpoint, band classification,
// compressor hysteresis and the tolerance register. Uses tah_pkg.
module tah_control
  import tah_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [TOL_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  tah_temp_t        in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output tah_out_t         out_data
);

  logic [TOL_W-1:0]      tol_r;
  logic [TEMP_W-1:0]     temp_r;
  logic [TEMP_W-1:0]     temp_nxt;
  logic [SETPOINT_W-1:0] target_r;
  logic [SETPOINT_W-1:0] target_nxt;
  logic                  comp_r;
  logic                  comp_nxt;
  tah_status_t           class_r;
  tah_status_t           class_nxt;
  tah_status_t           class_eval;
  logic                  out_valid_r;
  tah_out_t              out_data_r;
  tah_out_t              out_data_nxt;

  logic                  take;
  logic [SETPOINT_W:0]   band_hi;
  logic [SETPOINT_W-1:0] band_lo;
  logic                  lo_ok;
  logic                  is_hot;
  logic                  is_cold;

  assign in_ready = !out_valid_r || !out_stall;
  assign take     = in_valid && in_ready;

  always_comb begin
    temp_nxt   = temp_r;
    target_nxt = target_r;
    case (in_data.mode)
      MODE_SAMPLE: begin
        temp_nxt = in_data.temp;
      end
      MODE_UP: begin
        if (target_r != SETPOINT_MAX) begin
          target_nxt = target_r + SETPOINT_W'(1);
        end
      end
      MODE_DOWN: begin
        if (target_r != '0) begin
          target_nxt = target_r - SETPOINT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // a lower edge below zero never classes cold
  assign band_hi = {1'b0, target_nxt} + (SETPOINT_W + 1)'(tol_r);
  assign lo_ok   = target_nxt >= SETPOINT_W'(tol_r);
  assign band_lo = target_nxt - SETPOINT_W'(tol_r);
  assign is_hot  = TEMP_W'(band_hi) < temp_nxt;
  assign is_cold = lo_ok && (temp_nxt < TEMP_W'(band_lo));

  always_comb begin
    if (is_hot) begin
      class_eval = STATUS_HOT;
    end else if (is_cold) begin
      class_eval = STATUS_COLD;
    end else begin
      class_eval = STATUS_NORMAL;
    end
  end

  always_comb begin
    class_nxt = class_r;
    comp_nxt  = comp_r;
    if (in_data.mode == MODE_RESTART) begin
      comp_nxt = 1'b1;
    end else begin
      class_nxt = class_eval;
      if (class_eval == STATUS_HOT) begin
        comp_nxt = 1'b1;
      end else if (class_eval == STATUS_COLD) begin
        comp_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    out_data_nxt.temperature   = temp_nxt;
    out_data_nxt.status        = class_nxt;
    out_data_nxt.compressor_on = comp_nxt;
    out_data_nxt.setpoint      = target_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r       <= RESET_TOL;
      temp_r      <= RESET_TEMP;
      target_r    <= RESET_TARGET;
      comp_r      <= 1'b1;
      class_r     <= STATUS_NORMAL;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        tol_r <= cfg_wdata;
      end
      if (take) begin
        temp_r   <= temp_nxt;
        target_r <= target_nxt;
        comp_r   <= comp_nxt;
        class_r  <= class_nxt;
      end
      if (in_ready) begin
        out_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- tb/sv/thermostat_average_hysteresis_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for thermostat_average_hysteresis: a clocked driver
// and monitor around the block and a cycle-free predictor of its results.
// Depends on tah_pkg and the RTL top level only.
module thermostat_average_hysteresis_tb;
  import tah_pkg::*;

  localparam int AVERAGE_N      = AVERAGE_COUNT_DEF;
  localparam int SCALE_N        = SCALE_DIVISOR_DEF;
  localparam int CORRECTION_DIV = 33;
  localparam int SETTLE_CYCLES  = 12;
  localparam int PHASE_BEATS    = 280;
  localparam int RUN_LIMIT      = 400000;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [TOL_W-1:0] cfg_wdata = '0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  tah_in_t          in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  tah_out_t         out_data;

  thermostat_average_hysteresis #(
    .AVERAGE_COUNT(AVERAGE_N),
    .SCALE_DIVISOR(SCALE_N)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Predicted thermostat state
  logic [TOL_W-1:0]      band;
  logic [15:0]           acc_sum;
  logic [6:0]            acc_cnt;
  logic [TEMP_W-1:0]     cur_temp;
  logic [SETPOINT_W-1:0] cur_target;
  logic                  cur_comp;
  tah_status_t           cur_class;

  tah_in_t  pending_beats[$];
  tah_out_t expected_readings[$];

  int beats_queued = 0;
  int beats_taken  = 0;
  int errors       = 0;
  int cycle_count  = 0;
  int in_gap       = 0;
  int in_calm      = 0;
  int out_hold     = 0;
  int out_calm     = 0;

  // Stimulus-side view of target and average fill, tracked as beats are queued
  int gen_target = int'(RESET_TARGET);
  int gen_fill   = 0;

  initial begin
    band       = RESET_TOL;
    acc_sum    = '0;
    acc_cnt    = '0;
    cur_temp   = RESET_TEMP;
    cur_target = RESET_TARGET;
    cur_comp   = 1'b1;
    cur_class  = STATUS_NORMAL;
  end

  function automatic void reclassify();
    int t, hi, lo;
    t  = int'(cur_temp);
    hi = int'(cur_target) + int'(band);
    lo = int'(cur_target) - int'(band);
    if (t > hi) cur_class = STATUS_HOT;
    else if (t < lo) cur_class = STATUS_COLD;
    else cur_class = STATUS_NORMAL;
    // hysteresis: only the far side of the band flips the compressor
    if (!cur_comp && cur_class == STATUS_HOT) cur_comp = 1'b1;
    else if (cur_comp && cur_class == STATUS_COLD) cur_comp = 1'b0;
  endfunction

  function automatic void advance_thermostat(input tah_in_t beat);
    tah_out_t reading;
    int       avg;
    bit       gives;
    gives = 1'b1;
    case (beat.mode)
      MODE_SAMPLE: begin
        acc_sum = acc_sum + 16'(int'(beat.sample) / SCALE_N);
        acc_cnt = acc_cnt + 7'd1;
        if (int'(acc_cnt) < AVERAGE_N) begin
          gives = 1'b0;
        end else begin
          avg = (int'(acc_sum) + AVERAGE_N - 1) / AVERAGE_N;
          avg = avg - avg / CORRECTION_DIV;
          if (avg < int'(MIN_TEMP)) avg = int'(MIN_TEMP);
          cur_temp = TEMP_W'(avg);
          acc_sum  = '0;
          acc_cnt  = '0;
          reclassify();
        end
      end
      MODE_UP: begin
        if (cur_target != SETPOINT_MAX) cur_target = cur_target + 8'd1;
        reclassify();
      end
      MODE_DOWN: begin
        if (cur_target != '0) cur_target = cur_target - 8'd1;
        reclassify();
      end
      default: begin
        // restart keeps temperature and class, forces the compressor on
        acc_sum  = '0;
        acc_cnt  = '0;
        cur_comp = 1'b1;
      end
    endcase
    if (gives) begin
      reading.temperature   = cur_temp;
      reading.status        = cur_class;
      reading.compressor_on = cur_comp;
      reading.setpoint      = cur_target;
      expected_readings.push_back(reading);
    end
  endfunction

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  function automatic void report_mismatch(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    errors++;
  endfunction

  always @(posedge clk) begin : feed_beats
    bit taken;
    taken = in_valid && !in_stall;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (taken) begin
        advance_thermostat(in_data);
        beats_taken++;
      end
      // a stalled beat holds; otherwise idle out the gap or launch the next
      if (!in_valid || taken) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (pending_beats.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_beats.pop_front();
          in_gap   <= draw_wait(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_readings
    int       hold;
    tah_out_t want;
    hold = out_hold;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected reading, expected none, actual %0d/%0d/%0d/%0d", $time,
                 out_data.temperature, out_data.status, out_data.compressor_on,
                 out_data.setpoint);
        errors++;
      end else begin
        want = expected_readings.pop_front();
        if (out_data.temperature !== want.temperature)
          report_mismatch("temperature", 32'(want.temperature), 32'(out_data.temperature));
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(want.status), 32'(out_data.status));
        if (out_data.compressor_on !== want.compressor_on)
          report_mismatch("compressor_on", 32'(want.compressor_on),
                          32'(out_data.compressor_on));
        if (out_data.setpoint !== want.setpoint)
          report_mismatch("setpoint", 32'(want.setpoint), 32'(out_data.setpoint));
      end
      hold = draw_wait(out_calm);
    end else if (hold > 0) begin
      hold--;
    end
    if (!rst_n) hold = 0;
    out_hold  <= hold;
    out_stall <= (hold > 0);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("%0t: timeout with %0d readings outstanding", $time, expected_readings.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic queue_beat(input tah_mode_t m, input int s);
    tah_in_t beat;
    beat.mode   = m;
    beat.sample = SAMPLE_W'(s);
    pending_beats.push_back(beat);
    beats_queued++;
    case (m)
      MODE_SAMPLE:  gen_fill = (gen_fill + 1) % AVERAGE_N;
      MODE_UP:      if (gen_target < int'(SETPOINT_MAX)) gen_target++;
      MODE_DOWN:    if (gen_target > 0) gen_target--;
      MODE_RESTART: gen_fill = 0;
      default: begin
      end
    endcase
  endtask

  task automatic wait_quiet();
    while (beats_taken != beats_queued || expected_readings.size() != 0) @(posedge clk);
    // absorbed samples leave no reading; let them drain
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tolerance(input int v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= TOL_W'(v);
    band       = TOL_W'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic add_sequence();
    int pick, style, goal, raw, n;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      // complete an average, mostly aimed at the band edges
      style = $urandom_range(0, 9);
      goal  = gen_target + int'($urandom_range(0, 2 * int'(band) + 6)) - (int'(band) + 3);
      if (goal < 0) goal = 0;
      n = AVERAGE_N - gen_fill;
      repeat (n) begin
        if (style < 6) raw = goal * 66 / 32 + int'($urandom_range(0, 6)) - 3;
        else if (style < 8) raw = $urandom_range(0, 1023);
        else if (style == 8) raw = $urandom_range(0, 3);
        else raw = 1023 - int'($urandom_range(0, 3));
        if (raw < 0) raw = 0;
        if (raw > 1023) raw = 1023;
        queue_beat(MODE_SAMPLE, raw);
      end
    end else if (pick < 70) begin
      n = $urandom_range(1, 12);
      if ($urandom_range(0, 1) == 1) begin
        repeat (n) queue_beat(MODE_UP, $urandom_range(0, 1023));
      end else begin
        repeat (n) queue_beat(MODE_DOWN, $urandom_range(0, 1023));
      end
    end else if (pick < 80) begin
      // partial average broken off by a restart
      repeat ($urandom_range(0, AVERAGE_N - 1)) queue_beat(MODE_SAMPLE, $urandom_range(0, 1023));
      queue_beat(MODE_RESTART, $urandom_range(0, 1023));
    end else begin
      queue_beat(tah_mode_t'($urandom_range(0, 3)), $urandom_range(0, 1023));
    end
  endtask

  initial begin : run_test
    int tol_plan[7];
    int phase, start;
    tol_plan = '{15, 0, 5, 0, 10, 1, 0};
    tol_plan[3] = $urandom_range(0, 15);
    tol_plan[6] = $urandom_range(0, 15);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: restart, setpoint steps, full-scale and zero averages
    queue_beat(MODE_RESTART, 1023);
    queue_beat(MODE_UP, 'h2AA);
    queue_beat(MODE_DOWN, 'h155);
    repeat (AVERAGE_N) queue_beat(MODE_SAMPLE, 1023);
    // zero average clamps to the minimum and goes cold
    repeat (AVERAGE_N) queue_beat(MODE_SAMPLE, 0);
    queue_beat(MODE_UP, 0);
    queue_beat(MODE_RESTART, 0);
    wait_quiet();

    for (phase = 0; phase < 7; phase++) begin
      write_tolerance(tol_plan[phase]);
      start = beats_queued;
      // sweeps drive the setpoint into saturation at both ends
      if (phase == 0) repeat (32) queue_beat(MODE_DOWN, $urandom_range(0, 1023));
      if (phase == 1) repeat (260) queue_beat(MODE_UP, $urandom_range(0, 1023));
      if (phase == 3) repeat (240) queue_beat(MODE_DOWN, $urandom_range(0, 1023));
      while (beats_queued - start < PHASE_BEATS) add_sequence();
      wait_quiet();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/tah_pkg.sv
rtl/tah_prescale.sv
rtl/tah_split.sv
rtl/tah_average.sv
rtl/tah_correct.sv
rtl/tah_control.sv
rtl/thermostat_average_hysteresis.sv
tb/sv/thermostat_average_hysteresis_tb.sv
